>>> design/tcprr_pkg.sv
// ----------------------------------------------------------------------------
// tcprr_pkg: shared types and constants for the TCP reorder tracker
// Field widths, result codes, register indexes, controller states and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package tcprr_pkg;

  // Field widths of the input and result words.
  localparam int SEQ_W    = 32;
  localparam int LEN_W    = 16;
  localparam int TAG_W    = 10;
  localparam int STATUS_W = 2;
  localparam int IN_W     = 64;
  localparam int OUT_W    = 96;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_DROPPED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_SEQ_ERR = 2'd2;

  // Result kinds.
  localparam logic KIND_DELIVER = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  // Register index, taken from paddr[2].
  localparam logic REG_INIT_NEXT_SEQ = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_PLACE,
    ST_DRAIN_RD,
    ST_DRAIN_CHK,
    ST_STATUS
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_seg;
    logic scan_step;
    logic set_pos;
    logic shift_step;
    logic place;
    logic rd_head;
    logic deliver;
    logic seq_err;
    logic emit_status;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic scan_end;
    logic new_before;
    logic shift_done;
    logic empty;
    logic head_match;
    logic head_ahead;
    logic out_free;
  } dp_stat_t;

endpackage

>>> design/tcprr_ctrl.sv
// ----------------------------------------------------------------------------
// tcprr_ctrl: sequencing controller
// Walks one arrival through scan, shift, place, head drain and status.
// ----------------------------------------------------------------------------
module tcprr_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  tcprr_pkg::dp_stat_t stat,
  output tcprr_pkg::dp_cmd_t  cmd
);
  import tcprr_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = stat.full ? ST_DRAIN_RD : ST_SCAN;
        end
      end
      ST_SCAN: begin
        priority if (stat.scan_end) begin
          state_next = ST_PLACE;
        end else if (stat.new_before) begin
          state_next = ST_SHIFT;
        end else begin
          state_next = ST_SCAN;
        end
      end
      ST_SHIFT: begin
        if (stat.shift_done) begin
          state_next = ST_PLACE;
        end
      end
      ST_PLACE: begin
        state_next = ST_DRAIN_RD;
      end
      ST_DRAIN_RD: begin
        state_next = stat.empty ? ST_STATUS : ST_DRAIN_CHK;
      end
      ST_DRAIN_CHK: begin
        priority if (stat.head_match) begin
          if (stat.out_free) begin
            state_next = ST_DRAIN_RD;
          end
        end else begin
          state_next = ST_STATUS;
        end
      end
      ST_STATUS: begin
        if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready     = 1'b1;
        cmd.load_seg = in_valid;
      end
      ST_SCAN: begin
        priority if (stat.scan_end || stat.new_before) begin
          cmd.set_pos = 1'b1;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      ST_SHIFT: begin
        cmd.shift_step = 1'b1;
      end
      ST_PLACE: begin
        cmd.place = 1'b1;
      end
      ST_DRAIN_RD: begin
        cmd.rd_head = !stat.empty;
      end
      ST_DRAIN_CHK: begin
        priority if (stat.head_match) begin
          cmd.deliver = stat.out_free;
        end else if (!stat.head_ahead) begin
          cmd.seq_err = 1'b1;
        end else begin
          cmd.seq_err = 1'b0;
        end
      end
      ST_STATUS: begin
        cmd.emit_status = stat.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

>>> design/tcprr_dp.sv
// ----------------------------------------------------------------------------
// tcprr_dp: table memory, pointers and output register
// Holds the sorted segment table as a ring in one memory with a head pointer,
// the expected sequence number and the registered result word.
// ----------------------------------------------------------------------------
module tcprr_dp #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  tcprr_pkg::dp_cmd_t                cmd,
  output tcprr_pkg::dp_stat_t               stat,
  input  logic [tcprr_pkg::SEQ_W-1:0]       in_seq,
  input  logic [tcprr_pkg::LEN_W-1:0]       in_len,
  input  logic [tcprr_pkg::TAG_W-1:0]       in_tag,
  input  logic                              cfg_load,
  input  logic [tcprr_pkg::SEQ_W-1:0]       cfg_seq,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_kind,
  output logic [tcprr_pkg::TAG_W-1:0]       out_tag,
  output logic [tcprr_pkg::SEQ_W-1:0]       out_seq,
  output logic [tcprr_pkg::LEN_W-1:0]       out_len,
  output logic [tcprr_pkg::STATUS_W-1:0]    out_status,
  output logic [tcprr_pkg::SEQ_W-1:0]       out_expected,
  output logic                              out_last
);
  import tcprr_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    logic [LEN_W-1:0] len;
    logic [TAG_W-1:0] tag;
  } entry_t;

  entry_t              mem [QUEUE_DEPTH];
  entry_t              rdata;
  entry_t              seg;
  logic [PTR_W-1:0]    head;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    idx;
  logic [CNT_W-1:0]    pos;
  logic [SEQ_W-1:0]    next_seq;
  logic [STATUS_W-1:0] stat_code;

  logic                rd_en;
  logic [PTR_W-1:0]    rd_addr;
  logic                wr_en;
  logic [PTR_W-1:0]    wr_addr;
  entry_t              wr_data;
  logic [SEQ_W-1:0]    seq_sum;
  logic                out_load;

  // Physical slot of a logical table index, wrapping around the ring.
  function automatic logic [PTR_W-1:0] slot(input logic [PTR_W-1:0] h,
                                            input logic [CNT_W-1:0] i);
    logic [SUM_W-1:0] s;
    s = SUM_W'(h) + SUM_W'(i);
    if (s >= SUM_W'(QUEUE_DEPTH)) begin
      s = s - SUM_W'(QUEUE_DEPTH);
    end
    return s[PTR_W-1:0];
  endfunction

  // Wraparound order: a lies before b when a - b is negative.
  function automatic logic seq_before(input logic [SEQ_W-1:0] a,
                                      input logic [SEQ_W-1:0] b);
    logic [SEQ_W-1:0] d;
    d = a - b;
    return d[SEQ_W-1];
  endfunction

  // Status toward the controller.
  assign seq_sum         = next_seq + SEQ_W'(rdata.len);
  assign out_load        = !out_valid || out_ready;
  assign stat.full       = (count == CNT_W'(QUEUE_DEPTH));
  assign stat.scan_end   = (idx == count);
  assign stat.new_before = seq_before(seg.seq, rdata.seq);
  assign stat.shift_done = (idx == pos);
  assign stat.empty      = (count == '0);
  assign stat.head_match = (rdata.seq == next_seq);
  assign stat.head_ahead = seq_before(next_seq, rdata.seq);
  assign stat.out_free   = out_load;

  // Memory port selection.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = slot(head, '0);
    wr_en   = 1'b0;
    wr_addr = slot(head, pos);
    wr_data = seg;
    if (cmd.load_seg || cmd.rd_head) begin
      rd_en = 1'b1;
    end else if (cmd.scan_step) begin
      rd_en   = 1'b1;
      rd_addr = slot(head, idx + CNT_W'(1));
    end else if (cmd.set_pos) begin
      rd_en   = 1'b1;
      rd_addr = slot(head, count - CNT_W'(1));
    end else if (cmd.shift_step) begin
      rd_en   = 1'b1;
      rd_addr = slot(head, idx - CNT_W'(1));
      wr_en   = 1'b1;
      wr_addr = slot(head, idx + CNT_W'(1));
      wr_data = rdata;
    end else if (cmd.place) begin
      wr_en = 1'b1;
    end
  end

  // Table memory with registered read data.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // Arriving segment and scan position.
  always_ff @(posedge clk) begin
    if (cmd.load_seg) begin
      seg.seq <= in_seq;
      seg.len <= in_len;
      seg.tag <= in_tag;
    end
    if (cmd.load_seg) begin
      idx <= '0;
    end else if (cmd.scan_step) begin
      idx <= idx + CNT_W'(1);
    end else if (cmd.set_pos) begin
      idx <= count - CNT_W'(1);
    end else if (cmd.shift_step) begin
      idx <= idx - CNT_W'(1);
    end
    if (cmd.set_pos) begin
      pos <= idx;
    end
  end

  // Status code of the current arrival.
  always_ff @(posedge clk) begin
    if (cmd.load_seg) begin
      stat_code <= stat.full ? STATUS_DROPPED : STATUS_OK;
    end else if (cmd.seq_err && stat_code == STATUS_OK) begin
      stat_code <= STATUS_SEQ_ERR;
    end
  end

  // Ring pointer, fill count and expected sequence number.
  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      count    <= '0;
      next_seq <= '0;
    end else begin
      if (cmd.place) begin
        count <= count + CNT_W'(1);
      end else if (cmd.deliver) begin
        count <= count - CNT_W'(1);
        if (head == PTR_W'(QUEUE_DEPTH - 1)) begin
          head <= '0;
        end else begin
          head <= head + PTR_W'(1);
        end
      end
      if (cfg_load) begin
        next_seq <= cfg_seq;
      end else if (cmd.deliver) begin
        next_seq <= seq_sum;
      end
    end
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.deliver || cmd.emit_status) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.deliver) begin
      out_kind     <= KIND_DELIVER;
      out_tag      <= rdata.tag;
      out_seq      <= rdata.seq;
      out_len      <= rdata.len;
      out_status   <= STATUS_OK;
      out_expected <= seq_sum;
      out_last     <= 1'b0;
    end else if (cmd.emit_status) begin
      out_kind     <= KIND_STATUS;
      out_tag      <= '0;
      out_seq      <= '0;
      out_len      <= '0;
      out_status   <= stat_code;
      out_expected <= next_seq;
      out_last     <= 1'b1;
    end
  end

endmodule

>>> design/tcp_reorder_reassembly_tracker.sv
// ----------------------------------------------------------------------------
// tcp_reorder_reassembly_tracker: out-of-order segment reassembly tracker
// Inserts each segment into a wraparound-sorted table unless the table is full, drains
// in-order segments from its head and ends every arrival with one status word.
// ----------------------------------------------------------------------------
// Flow: a dropped arrival (table full) skips scan, shift and place. Output
//   stalls hold up each word. The next arrival can be taken in the cycle after
//   the status word is registered. Reset clears fill count, head and expected
//   sequence (to 0); table stays undefined.
module tcp_reorder_reassembly_tracker #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  // Input words.
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [tcprr_pkg::IN_W-1:0]      s_tdata,  // segment_seq, segment_len, segment_tag
  // Result words.
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [tcprr_pkg::OUT_W-1:0]     m_tdata,  // out_tag, out_seq, out_len, status,
                                                    // expected_seq
  output logic                            m_tuser,  // kind
  output logic                            m_tlast,  // is_last
  // Configuration port.
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tcprr_pkg::APB_AW-1:0]    paddr,
  input  logic [tcprr_pkg::APB_DW-1:0]    pwdata,
  output logic [tcprr_pkg::APB_DW-1:0]    prdata,
  output logic                            pready
);
  import tcprr_pkg::*;

  dp_cmd_t              cmd;
  dp_stat_t             stat;
  logic [SEQ_W-1:0]     init_next_seq;
  logic                 cfg_load;
  logic [TAG_W-1:0]     o_tag;
  logic [SEQ_W-1:0]     o_seq;
  logic [LEN_W-1:0]     o_len;
  logic [STATUS_W-1:0]  o_status;
  logic [SEQ_W-1:0]     o_expected;

  // Configuration register: a write also reloads the expected sequence.
  assign pready   = 1'b1;
  assign cfg_load = psel && penable && pwrite && pready && (paddr[2] == REG_INIT_NEXT_SEQ);
  assign prdata   = (paddr[2] == REG_INIT_NEXT_SEQ) ? init_next_seq : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      init_next_seq <= '0;
    end else if (cfg_load) begin
      init_next_seq <= pwdata;
    end
  end

  tcprr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tcprr_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .in_seq       (s_tdata[31:0]),
    .in_len       (s_tdata[47:32]),
    .in_tag       (s_tdata[57:48]),
    .cfg_load     (cfg_load),
    .cfg_seq      (pwdata),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_kind     (m_tuser),
    .out_tag      (o_tag),
    .out_seq      (o_seq),
    .out_len      (o_len),
    .out_status   (o_status),
    .out_expected (o_expected),
    .out_last     (m_tlast)
  );

  // Pack the result word, first field lowest.
  assign m_tdata = {4'b0, o_expected, o_status, o_len, o_seq, o_tag};

  // Only status words close an arrival.
  a_last_is_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == m_tlast))
    else $error("last flag and kind disagree");

  // Delivered words always carry status ok.
  a_deliver_ok: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == KIND_DELIVER)) |-> (m_tdata[59:58] == STATUS_OK))
    else $error("delivered word with nonzero status");

  // An accepted arrival closes the input until it is finished.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while an arrival is in progress");

endmodule
